// ===== sv/mttc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttc_pkg
// shared types, codes and constants of the tap tempo clock source
// ----------------------------------------------------------------------------
package mttc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int IN_TIME_W      = 32;

    localparam logic [2:0] ACT_RAW    = 3'd0;
    localparam logic [2:0] ACT_TAP    = 3'd1;
    localparam logic [2:0] ACT_START  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;
    localparam logic [2:0] ACT_CANCEL = 3'd5;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [3:0] SYSTEM_HI   = 4'hF;
    localparam logic [7:0] MIDI_CLOCK  = 8'hF8;
    localparam logic [7:0] MIDI_START  = 8'hFA;
    localparam logic [7:0] MIDI_STOP   = 8'hFC;

    localparam int unsigned TAP_LIMIT   = 400000;
    localparam logic [24:0] TEMPO_SCALE = 25'd18750000;
    localparam logic [7:0]  BPM_MIN     = 8'd40;
    localparam logic [7:0]  BPM_MAX     = 8'd240;
    localparam logic [7:0]  BPM_RESET   = 8'd120;
    localparam logic [7:0]  TAP_SAT     = 8'd255;

    // scale times an 8 bit tap count
    localparam int NUM_W = 33;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEND,
        OP_TAP,
        OP_START,
        OP_STOP,
        OP_CANCEL
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           byte_val;
        logic [IN_TIME_W-1:0] interval;
    } t_cmd;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       run_flag;
        logic       clock_enable;
        logic [7:0] tempo_bpm;
        logic       tempo_updated;
    } t_res;

endpackage

// ===== sv/mttc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttc_in_if / mttc_out_if
// valid/ready channels for event items and result items
// ----------------------------------------------------------------------------
interface mttc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  midi_byte;
    logic [31:0] tap_interval;
    logic        tick_is_internal;

    modport source (output valid, action, midi_byte, tap_interval, tick_is_internal,
                    input ready);
    modport sink   (input valid, action, midi_byte, tap_interval, tick_is_internal,
                    output ready);
endinterface

interface mttc_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       run_flag;
    logic       clock_enable;
    logic [7:0] tempo_bpm;
    logic       tempo_updated;

    modport source (output valid, send_valid, send_byte, run_flag, clock_enable,
                    tempo_bpm, tempo_updated, input ready);
    modport sink   (input valid, send_valid, send_byte, run_flag, clock_enable,
                    tempo_bpm, tempo_updated, output ready);
endinterface

// ===== sv/mttc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttc_front
// accepts event items, decodes them into commands and queues them
// ----------------------------------------------------------------------------
module mttc_front
    import mttc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mttc_in_if.sink    i_in,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_cmd             w_cmd;
    logic             w_push;

    always_comb begin
        w_cmd.op       = OP_NONE;
        w_cmd.byte_val = i_in.midi_byte;
        w_cmd.interval = i_in.tap_interval;
        case (i_in.action)
            ACT_RAW: begin
                if (i_in.midi_byte[7:4] != SYSTEM_HI
                    || i_in.midi_byte inside {SYSEX_START, SYSEX_END}) begin
                    w_cmd.op = OP_SEND;
                end
            end
            ACT_TAP:    w_cmd.op = OP_TAP;
            ACT_START:  w_cmd.op = OP_START;
            ACT_STOP:   w_cmd.op = OP_STOP;
            ACT_TICK: begin
                w_cmd.byte_val = MIDI_CLOCK;
                if (i_in.tick_is_internal) begin
                    w_cmd.op = OP_SEND;
                end
            end
            ACT_CANCEL: w_cmd.op = OP_CANCEL;
            default:    w_cmd.op = OP_NONE;
        endcase
    end

    assign i_in.ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid)
        else $error("command popped from empty queue");

endmodule

// ===== sv/mttc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttc_back
// executes queued commands: transport state, tap averaging, tempo divider
// ----------------------------------------------------------------------------
module mttc_back
    import mttc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_continuous,
    mttc_out_if.source o_out
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_running;
    logic [7:0]            r_tap_count;
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [7:0]            r_bpm;
    logic [NUM_W-1:0]      r_num;
    logic [TIME_WIDTH-1:0] r_rem;
    logic [TIME_WIDTH-1:0] r_den;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_zero;
    logic                  r_out_valid;
    t_res                  r_res;

    logic                  w_slot;
    logic [TIME_WIDTH-1:0] w_t;
    logic                  w_tap_ok;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic [NUM_W-1:0]      w_num;
    logic [7:0]            w_cnt_inc;
    logic                  w_run_nxt;
    t_res                  w_imm_res;
    logic [TIME_WIDTH:0]   w_rem_sh;
    logic [TIME_WIDTH:0]   w_diff;
    logic [7:0]            w_bpm_clip;
    logic                  w_res_load;

    assign w_slot    = !r_out_valid || o_out.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && w_slot;

    assign w_t       = TIME_WIDTH'(i_cmd.interval);
    assign w_tap_ok  = (r_tap_count != '0) && (w_t < TIME_WIDTH'(TAP_LIMIT));
    assign w_elapsed = r_elapsed + w_t;
    assign w_num     = NUM_W'(TEMPO_SCALE) * NUM_W'(r_tap_count);
    assign w_cnt_inc = (r_tap_count == TAP_SAT) ? r_tap_count : r_tap_count + 8'd1;

    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_den};

    // a result item is loaded either straight from a command or after the divider
    assign w_res_load = (o_cmd_pop && !(i_cmd.op == OP_TAP && w_tap_ok))
                        || (r_state == S_DONE && w_slot);

    always_comb begin
        if (r_zero || r_num > NUM_W'(BPM_MAX)) begin
            w_bpm_clip = BPM_MAX;
        end else if (r_num < NUM_W'(BPM_MIN)) begin
            w_bpm_clip = BPM_MIN;
        end else begin
            w_bpm_clip = r_num[7:0];
        end
    end

    always_comb begin
        w_run_nxt = r_running;
        w_imm_res = '0;
        case (i_cmd.op)
            OP_SEND: begin
                w_imm_res.send_valid = 1'b1;
                w_imm_res.send_byte  = i_cmd.byte_val;
            end
            OP_START: begin
                if (!r_running) begin
                    w_imm_res.send_valid = 1'b1;
                    w_imm_res.send_byte  = MIDI_START;
                    w_run_nxt            = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_running) begin
                    w_imm_res.send_valid = 1'b1;
                    w_imm_res.send_byte  = MIDI_STOP;
                    w_run_nxt            = 1'b0;
                end
            end
            default: begin
            end
        endcase
        w_imm_res.run_flag      = w_run_nxt;
        w_imm_res.clock_enable  = w_run_nxt || i_continuous;
        w_imm_res.tempo_bpm     = r_bpm;
        w_imm_res.tempo_updated = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_tap_count <= '0;
            r_elapsed   <= '0;
            r_bpm       <= BPM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.op == OP_TAP && w_tap_ok) begin
                            r_elapsed   <= w_elapsed;
                            r_den       <= w_elapsed;
                            r_num       <= w_num;
                            r_rem       <= '0;
                            r_cnt       <= '0;
                            r_zero      <= (w_elapsed == '0);
                            r_tap_count <= w_cnt_inc;
                            r_state     <= (w_elapsed == '0) ? S_DONE : S_DIV;
                        end else begin
                            if (i_cmd.op == OP_TAP) begin
                                r_tap_count <= 8'd1;
                                r_elapsed   <= '0;
                            end else if (i_cmd.op == OP_CANCEL) begin
                                r_tap_count <= '0;
                            end
                            r_running   <= w_run_nxt;
                            r_res       <= w_imm_res;
                        end
                    end
                end
                S_DIV: begin
                    if (!w_diff[TIME_WIDTH]) begin
                        r_rem <= w_diff[TIME_WIDTH-1:0];
                    end else begin
                        r_rem <= w_rem_sh[TIME_WIDTH-1:0];
                    end
                    r_num <= {r_num[NUM_W-2:0], !w_diff[TIME_WIDTH]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_bpm                   <= w_bpm_clip;
                        r_res.send_valid        <= 1'b0;
                        r_res.send_byte         <= '0;
                        r_res.run_flag          <= r_running;
                        r_res.clock_enable      <= r_running || i_continuous;
                        r_res.tempo_bpm         <= w_bpm_clip;
                        r_res.tempo_updated     <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.send_valid    = r_res.send_valid;
    assign o_out.send_byte     = r_res.send_byte;
    assign o_out.run_flag      = r_res.run_flag;
    assign o_out.clock_enable  = r_res.clock_enable;
    assign o_out.tempo_bpm     = r_res.tempo_bpm;
    assign o_out.tempo_updated = r_res.tempo_updated;

    a_bpm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.tempo_bpm >= BPM_MIN && o_out.tempo_bpm <= BPM_MAX))
        else $error("tempo out of range");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.send_valid) |-> (o_out.send_byte == '0))
        else $error("byte present without send");

    a_clk_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.clock_enable == (o_out.run_flag || i_continuous)))
        else $error("clock enable mismatch");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(NUM_W)))
        else $error("divider ran past its last step");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && w_slot))
        else $error("command taken while busy");

endmodule

// ===== sv/midi_tap_tempo_clock_source.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_tap_tempo_clock_source
// midi clock source: byte filter, transport, tap tempo averaging
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, midi_byte, tap_interval, tick_is_internal
//  o_out     out  valid/ready    send_valid, send_byte, run_flag, clock_enable,
//                                tempo_bpm, tempo_updated
//  i_cfg_*   in   write enable   continuous_mode
//
//  one result per item; most items load it straight from the command, while
//  a tap that recomputes the tempo goes through the bit-serial restoring
//  divider
//  synchronous active-low reset, no clearing pass
//  a two-item queue parts the front end from the back end; a registered
//  result lets the back end take the next command as the result is taken
// ----------------------------------------------------------------------------
module midi_tap_tempo_clock_source
    import mttc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mttc_in_if.sink    i_in,
    mttc_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic r_continuous;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_continuous <= 1'b0;
        end else if (i_cfg_we) begin
            r_continuous <= i_cfg_wdata;
        end
    end

    mttc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    mttc_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .i_continuous (r_continuous),
        .o_out        (o_out)
    );

endmodule
